// ===== sv/i2crm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crm_pkg
// Types and constants shared by the I2C register master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2crm_pkg;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_READ   = 2'd2,
		ACT_SUPPLY = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START     = 4'd1,
		PH_ADDRW     = 4'd2,
		PH_REG       = 4'd3,
		PH_RESTART   = 4'd4,
		PH_ADDRR     = 4'd5,
		PH_WAITDATA  = 4'd6,
		PH_DATAW     = 4'd7,
		PH_READ      = 4'd8,
		PH_STOP_OK   = 4'd9,
		PH_STOP_FAIL = 4'd10
	} phase_t;

	typedef enum logic {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_ACK_TIMEOUT    = 1'b1
	} reg_index_t;

	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd150;
	localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
	localparam int         PADDR_WIDTH       = 3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] reg_address;
		logic [7:0] byte_count;
		logic [7:0] write_data;
		logic       sda_in;
	} in_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic [7:0] read_data;
		logic       read_valid;
		logic       read_last;
		logic       need_write_byte;
		logic       done_res;
		logic       failed;
		logic       busy_res;
	} out_t;

endpackage

`default_nettype wire

// ===== sv/i2c_register_master_top.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master_top
// I2C master for register writes and reads, stepped by tick items.
// ----------------------------------------------------------------------------
// Every input item produces exactly one result. The block takes one item per
// clock cycle while the output side is not stalled; each item passes an input
// register and then a result register, where its result is presented. The bus
// sequence state is updated once per item in the single stage between those
// registers, which is what lets items follow back to back.
// Pin levels change only on tick items; begin and supply items only load.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_master_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire i2crm_pkg::in_t            in_data,
	output logic                           out_valid,
	input  wire                            out_ready,
	output i2crm_pkg::out_t                out_data,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [i2crm_pkg::PADDR_WIDTH-1:0] paddr,
	input  wire [31:0]                     pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import i2crm_pkg::*;

	logic [6:0] dev_addr_q;
	logic [7:0] ack_timeout_q;

	in_t        item_s1;
	logic       valid_s1;
	logic       advance;

	phase_t     phase_q, phase_d;
	logic [2:0] sub_q, sub_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] left_q, left_d;
	logic [7:0] held_q, held_d;
	logic       is_read_q, is_read_d;
	logic [7:0] wait_q, wait_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	out_t       res;
	logic [7:0] left_dec;
	logic [7:0] shift_in;
	logic [3:0] bit_inc;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= '0;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_index_t'(paddr[2]))
				REG_DEVICE_ADDRESS: dev_addr_q    <= pwdata[6:0];
				REG_ACK_TIMEOUT:    ack_timeout_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_index_t'(paddr[2]))
			REG_DEVICE_ADDRESS: prdata = {25'd0, dev_addr_q};
			REG_ACK_TIMEOUT:    prdata = {24'd0, ack_timeout_q};
			default: ;
		endcase
	end

	// Flow control: the stage moves when the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	assign left_dec = left_q - 8'd1;
	assign shift_in = {shift_q[6:0], item_s1.sda_in};
	assign bit_inc  = bit_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		sub_d     = sub_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		left_d    = left_q;
		held_d    = held_q;
		is_read_d = is_read_q;
		wait_d    = wait_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		res       = '0;

		case (action_t'(item_s1.action))
			ACT_WRITE, ACT_READ: begin
				if (phase_q == PH_IDLE) begin
					held_d    = item_s1.reg_address;
					left_d    = item_s1.byte_count;
					is_read_d = (item_s1.action == ACT_READ);
					wait_d    = '0;
					shift_d   = '0;
					phase_d   = PH_START;
					sub_d     = '0;
					bit_d     = '0;
				end
			end
			ACT_SUPPLY: begin
				if (phase_q == PH_WAITDATA) begin
					phase_d = PH_DATAW;
					sub_d   = '0;
					bit_d   = '0;
					shift_d = item_s1.write_data;
				end
			end
			default: begin
				unique case (phase_q)
					PH_START, PH_RESTART: begin
						case (sub_q)
							3'd0: begin sda_d = 1'b1; sub_d = 3'd1; end
							3'd1: begin scl_d = 1'b1; sub_d = 3'd2; end
							3'd2: begin sda_d = 1'b0; sub_d = 3'd3; end
							default: begin
								scl_d = 1'b0;
								sub_d = '0;
								bit_d = '0;
								if (phase_q == PH_START) begin
									phase_d = PH_ADDRW;
									shift_d = {dev_addr_q, 1'b0};
								end else begin
									phase_d = PH_ADDRR;
									shift_d = {dev_addr_q, 1'b1};
								end
							end
						endcase
					end
					PH_ADDRW, PH_REG, PH_ADDRR, PH_DATAW: begin
						if (bit_q < BITS_PER_BYTE) begin
							case (sub_q)
								3'd0: begin
									sda_d   = shift_q[7];
									shift_d = {shift_q[6:0], 1'b0};
									sub_d   = 3'd1;
								end
								3'd1: begin scl_d = 1'b1; sub_d = 3'd2; end
								default: begin
									scl_d = 1'b0;
									bit_d = bit_inc;
									sub_d = '0;
								end
							endcase
						end else begin
							case (sub_q)
								3'd0: begin sda_d = 1'b1; sub_d = 3'd1; end
								3'd1: begin
									scl_d  = 1'b1;
									wait_d = '0;
									sub_d  = 3'd2;
								end
								3'd2: begin
									if (!item_s1.sda_in) begin
										sub_d = 3'd3;
									end else if (wait_q >= ack_timeout_q) begin
										phase_d = PH_STOP_FAIL;
										sub_d   = '0;
										bit_d   = '0;
									end else begin
										wait_d = wait_q + 8'd1;
									end
								end
								default: begin
									// Acknowledge seen: pick the next part of the transfer.
									scl_d = 1'b0;
									sub_d = '0;
									bit_d = '0;
									case (phase_q)
										PH_ADDRW: begin
											phase_d = PH_REG;
											shift_d = held_q;
										end
										PH_REG: begin
											if (is_read_q)
												phase_d = PH_RESTART;
											else if (left_q != 8'd0)
												phase_d = PH_WAITDATA;
											else
												phase_d = PH_STOP_OK;
										end
										PH_ADDRR: begin
											if (left_q != 8'd0) begin
												phase_d = PH_READ;
												shift_d = '0;
											end else begin
												phase_d = PH_STOP_OK;
											end
										end
										default: begin
											left_d  = left_dec;
											phase_d = (left_dec != 8'd0) ? PH_WAITDATA
												: PH_STOP_OK;
										end
									endcase
								end
							endcase
						end
					end
					PH_READ: begin
						if (bit_q < BITS_PER_BYTE) begin
							if (sub_q == 3'd0) begin
								scl_d = 1'b0;
								sub_d = 3'd1;
							end else begin
								scl_d   = 1'b1;
								shift_d = shift_in;
								bit_d   = bit_inc;
								sub_d   = '0;
								if (bit_inc == BITS_PER_BYTE) begin
									res.read_valid = 1'b1;
									res.read_data  = shift_in;
									res.read_last  = (left_q == 8'd1);
								end
							end
						end else begin
							case (sub_q)
								3'd0: begin
									// Acknowledge every byte but the last.
									scl_d = 1'b0;
									sda_d = (left_q == 8'd1);
									sub_d = 3'd1;
								end
								3'd1: begin scl_d = 1'b1; sub_d = 3'd2; end
								3'd2: begin scl_d = 1'b0; sub_d = 3'd3; end
								default: begin
									sda_d  = 1'b1;
									left_d = left_dec;
									sub_d  = '0;
									bit_d  = '0;
									if (left_dec != 8'd0) begin
										phase_d = PH_READ;
										shift_d = '0;
									end else begin
										phase_d = PH_STOP_OK;
									end
								end
							endcase
						end
					end
					PH_STOP_OK, PH_STOP_FAIL: begin
						case (sub_q)
							3'd0: begin
								scl_d = 1'b0;
								sda_d = 1'b1;
								sub_d = 3'd1;
							end
							3'd1: begin sda_d = 1'b0; sub_d = 3'd2; end
							3'd2: begin scl_d = 1'b1; sub_d = 3'd3; end
							default: begin
								sda_d        = 1'b1;
								res.done_res = 1'b1;
								res.failed   = (phase_q == PH_STOP_FAIL);
								phase_d      = PH_IDLE;
								sub_d        = '0;
								bit_d        = '0;
							end
						endcase
					end
					default: ;
				endcase
			end
		endcase

		res.scl_out         = scl_d;
		res.sda_out         = sda_d;
		res.need_write_byte = (phase_d == PH_WAITDATA);
		res.busy_res        = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sub_q     <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			left_q    <= '0;
			held_q    <= '0;
			is_read_q <= 1'b0;
			wait_q    <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_d;
			sub_q     <= sub_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			left_q    <= left_d;
			held_q    <= held_d;
			is_read_q <= is_read_d;
			wait_q    <= wait_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= res;
		end
	end

endmodule

`default_nettype wire

// ===== tb/i2c_register_master_top_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master_top_tb
// Self-checking bench for the I2C register master: it drives tick, begin and
// supply items, predicts every result with its own bus sequencer model and
// compares each result field by field under varying idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_master_top_tb;

	import i2crm_pkg::*;

	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_t                    in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_t                   out_data;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_WIDTH-1:0] paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	// Bus sequencer state as the block should hold it.
	phase_t     ph;
	logic [2:0] sub;
	logic [3:0] bitcnt;
	logic [7:0] shreg;
	logic [7:0] remaining;
	logic [7:0] held_reg;
	logic       rd_mode;
	logic [7:0] ack_waits;
	logic       scl_q;
	logic       sda_q;
	logic [6:0] dev_addr;
	logic [7:0] ack_limit;

	out_t expected_results[$];
	bit   abort_xfer;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	int   mismatches;
	int   useful_items;
	int   results_checked;
	int   transfers_done;
	int   transfers_failed;
	int   bytes_read;
	int   idle_cycles;

	i2c_register_master_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic void go_to(phase_t p);
		ph = p;
		sub = 3'd0;
		bitcnt = 4'd0;
	endfunction

	function automatic out_t i2c_step(in_t it);
		out_t r;
		r = '0;
		case (it.action)
			ACT_WRITE, ACT_READ: begin
				if (ph == PH_IDLE) begin
					held_reg = it.reg_address;
					remaining = it.byte_count;
					rd_mode = (it.action == ACT_READ);
					ack_waits = 8'd0;
					shreg = 8'd0;
					go_to(PH_START);
				end
			end
			ACT_SUPPLY: begin
				if (ph == PH_WAITDATA) begin
					go_to(PH_DATAW);
					shreg = it.write_data;
				end
			end
			default: begin
				case (ph)
					PH_START, PH_RESTART: begin
						if (sub == 3'd0) begin
							sda_q = 1'b1;
							sub = 3'd1;
						end else if (sub == 3'd1) begin
							scl_q = 1'b1;
							sub = 3'd2;
						end else if (sub == 3'd2) begin
							sda_q = 1'b0;
							sub = 3'd3;
						end else begin
							scl_q = 1'b0;
							if (ph == PH_START) begin
								go_to(PH_ADDRW);
								shreg = {dev_addr, 1'b0};
							end else begin
								go_to(PH_ADDRR);
								shreg = {dev_addr, 1'b1};
							end
						end
					end
					PH_ADDRW, PH_REG, PH_ADDRR, PH_DATAW: begin
						if (bitcnt < BITS_PER_BYTE) begin
							if (sub == 3'd0) begin
								sda_q = shreg[7];
								shreg = {shreg[6:0], 1'b0};
								sub = 3'd1;
							end else if (sub == 3'd1) begin
								scl_q = 1'b1;
								sub = 3'd2;
							end else begin
								scl_q = 1'b0;
								bitcnt++;
								sub = 3'd0;
							end
						end else if (sub == 3'd0) begin
							sda_q = 1'b1;
							sub = 3'd1;
						end else if (sub == 3'd1) begin
							scl_q = 1'b1;
							ack_waits = 8'd0;
							sub = 3'd2;
						end else if (sub == 3'd2) begin
							// A low sample is the acknowledge; highs count toward the timeout.
							if (!it.sda_in) sub = 3'd3;
							else if (ack_waits >= ack_limit) go_to(PH_STOP_FAIL);
							else ack_waits++;
						end else begin
							scl_q = 1'b0;
							case (ph)
								PH_ADDRW: begin
									go_to(PH_REG);
									shreg = held_reg;
								end
								PH_REG: begin
									if (rd_mode) go_to(PH_RESTART);
									else go_to(remaining != 0 ? PH_WAITDATA : PH_STOP_OK);
								end
								PH_ADDRR: begin
									if (remaining != 0) begin
										go_to(PH_READ);
										shreg = 8'd0;
									end else begin
										go_to(PH_STOP_OK);
									end
								end
								default: begin
									remaining--;
									go_to(remaining != 0 ? PH_WAITDATA : PH_STOP_OK);
								end
							endcase
						end
					end
					PH_READ: begin
						if (bitcnt < BITS_PER_BYTE) begin
							if (sub == 3'd0) begin
								scl_q = 1'b0;
								sub = 3'd1;
							end else begin
								scl_q = 1'b1;
								shreg = {shreg[6:0], it.sda_in};
								bitcnt++;
								sub = 3'd0;
								if (bitcnt == BITS_PER_BYTE) begin
									r.read_valid = 1'b1;
									r.read_data = shreg;
									r.read_last = (remaining == 8'd1);
								end
							end
						end else if (sub == 3'd0) begin
							// The last byte is answered with a not-acknowledge.
							scl_q = 1'b0;
							sda_q = (remaining == 8'd1);
							sub = 3'd1;
						end else if (sub == 3'd1) begin
							scl_q = 1'b1;
							sub = 3'd2;
						end else if (sub == 3'd2) begin
							scl_q = 1'b0;
							sub = 3'd3;
						end else begin
							sda_q = 1'b1;
							remaining--;
							if (remaining != 0) begin
								go_to(PH_READ);
								shreg = 8'd0;
							end else begin
								go_to(PH_STOP_OK);
							end
						end
					end
					PH_STOP_OK, PH_STOP_FAIL: begin
						if (sub == 3'd0) begin
							scl_q = 1'b0;
							sda_q = 1'b1;
							sub = 3'd1;
						end else if (sub == 3'd1) begin
							sda_q = 1'b0;
							sub = 3'd2;
						end else if (sub == 3'd2) begin
							scl_q = 1'b1;
							sub = 3'd3;
						end else begin
							sda_q = 1'b1;
							r.done_res = 1'b1;
							r.failed = (ph == PH_STOP_FAIL);
							go_to(PH_IDLE);
						end
					end
					default: ;
				endcase
			end
		endcase
		r.scl_out = scl_q;
		r.sda_out = sda_q;
		r.need_write_byte = (ph == PH_WAITDATA);
		r.busy_res = (ph != PH_IDLE);
		return r;
	endfunction

	// Next item for a transfer in flight. The quiet form is strictly well formed;
	// the noisy form mixes in ignored items and the odd high sample on an
	// acknowledge.
	function automatic in_t bus_item(bit noisy);
		in_t         it;
		bit          polling;
		int unsigned r;
		it.action = ACT_TICK;
		it.reg_address = 8'($urandom);
		it.byte_count = 8'($urandom);
		it.write_data = 8'($urandom);
		it.sda_in = 1'($urandom);
		r = $urandom_range(0, 99);
		polling = (ph == PH_ADDRW || ph == PH_REG || ph == PH_ADDRR || ph == PH_DATAW)
			&& bitcnt == BITS_PER_BYTE && sub == 3'd2;
		if (ph == PH_WAITDATA) begin
			if (!noisy || r < 85) it.action = ACT_SUPPLY;
			else if (r >= 95) it.action = ACT_WRITE;
		end else if (ph != PH_IDLE && noisy && r >= 97) begin
			it.action = (r == 99) ? ACT_SUPPLY : ACT_READ;
		end
		if (polling) it.sda_in = abort_xfer || (noisy && $urandom_range(0, 9) == 0);
		else if (!noisy && ph == PH_READ) it.sda_in = remaining[0];
		if (!noisy && it.action == ACT_SUPPLY) it.write_data = remaining[0] ? 8'hFF : 8'h00;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(in_t it);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (((it.action == ACT_WRITE || it.action == ACT_READ) && ph == PH_IDLE)
			|| (it.action == ACT_SUPPLY && ph == PH_WAITDATA)
			|| (it.action == ACT_TICK && ph != PH_IDLE))
			useful_items++;
		expected_results.push_back(i2c_step(it));
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic read_reg_check(reg_index_t idx, logic [7:0] want, logic [7:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_WIDTH'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", want, prdata[7:0] & mask);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_WIDTH'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DEVICE_ADDRESS) dev_addr = value[6:0];
		else ack_limit = value[7:0];
		@(negedge clk);
		if (idx == REG_DEVICE_ADDRESS) read_reg_check(idx, {1'b0, dev_addr}, 8'h7F);
		else read_reg_check(idx, ack_limit, 8'hFF);
	endtask

	task automatic run_transfer(action_t op, logic [7:0] reg_addr, logic [7:0] count,
		bit nack);
		in_t it;
		it = bus_item(1'b0);
		it.action = op;
		it.reg_address = reg_addr;
		it.byte_count = count;
		abort_xfer = nack;
		send_item(it);
		while (ph != PH_IDLE) send_item(bus_item(1'b0));
	endtask

	task automatic test_register_access();
		read_reg_check(REG_DEVICE_ADDRESS, 8'h00, 8'h7F);
		read_reg_check(REG_ACK_TIMEOUT, ACK_TIMEOUT_RESET, 8'hFF);
		write_reg(REG_DEVICE_ADDRESS, 32'h7F);
		write_reg(REG_ACK_TIMEOUT, 32'hFF);
		write_reg(REG_ACK_TIMEOUT, 32'd2);
	endtask

	task automatic test_directed_transfers();
		run_transfer(ACT_WRITE, 8'hFF, 8'd2, 1'b0);
		run_transfer(ACT_READ, 8'h00, 8'd2, 1'b0);
		// Zero-length transfers stop right after the register or read address byte.
		run_transfer(ACT_WRITE, 8'h5A, 8'd0, 1'b0);
		run_transfer(ACT_READ, 8'hA5, 8'd0, 1'b0);
		run_transfer(ACT_WRITE, 8'h80, 8'hFF, 1'b1);
		wait_for_results();
		// With a zero timeout the first high sample already fails.
		write_reg(REG_ACK_TIMEOUT, 32'd0);
		run_transfer(ACT_READ, 8'h01, 8'hFF, 1'b1);
		wait_for_results();
	endtask

	task automatic test_ignored_items();
		in_t it;
		it = bus_item(1'b0);
		send_item(it);
		it.action = ACT_SUPPLY;
		send_item(it);
		abort_xfer = 1'b0;
		it.action = ACT_WRITE;
		it.byte_count = 8'd1;
		send_item(it);
		// Neither a second begin nor an early supply may disturb the transfer.
		it.action = ACT_READ;
		it.byte_count = 8'hFF;
		send_item(it);
		it.action = ACT_SUPPLY;
		send_item(it);
		while (ph != PH_IDLE) send_item(bus_item(1'b0));
		wait_for_results();
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
		int          target;
		int unsigned r;
		in_t         it;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		target = useful_items + n;
		while (useful_items < target) begin
			it = bus_item(1'b1);
			if (ph == PH_IDLE) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					it.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
					if (r < 76) it.byte_count = 8'($urandom_range(0, 2));
					// Long transfers are cut short by a missing acknowledge.
					abort_xfer = it.byte_count > 8'd4 || $urandom_range(0, 19) == 0;
				end else if (r < 90) begin
					it.action = ACT_SUPPLY;
				end
			end
			send_item(it);
		end
		wait_for_results();
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: %0h", out_data);
				mismatches++;
			end else begin
				out_t want;
				want = expected_results.pop_front();
				check_field("scl_out", 8'(want.scl_out), 8'(out_data.scl_out));
				check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
				check_field("read_data", want.read_data, out_data.read_data);
				check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
				check_field("read_last", 8'(want.read_last), 8'(out_data.read_last));
				check_field("need_write_byte", 8'(want.need_write_byte),
					8'(out_data.need_write_byte));
				check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
				check_field("failed", 8'(want.failed), 8'(out_data.failed));
				check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				results_checked++;
				if (want.done_res) transfers_done++;
				if (want.failed) transfers_failed++;
				if (want.read_valid) bytes_read++;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatches = 0;
		useful_items = 0;
		results_checked = 0;
		transfers_done = 0;
		transfers_failed = 0;
		bytes_read = 0;
		abort_xfer = 1'b0;
		dev_addr = 7'd0;
		ack_limit = ACK_TIMEOUT_RESET;
		ph = PH_IDLE;
		sub = 3'd0;
		bitcnt = 4'd0;
		shreg = 8'd0;
		remaining = 8'd0;
		held_reg = 8'd0;
		rd_mode = 1'b0;
		ack_waits = 8'd0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_access();
		test_directed_transfers();
		test_ignored_items();

		write_reg(REG_DEVICE_ADDRESS, $urandom_range(0, 127));
		write_reg(REG_ACK_TIMEOUT, 32'(ACK_TIMEOUT_RESET));
		test_random_traffic(330, 0, 0);
		write_reg(REG_DEVICE_ADDRESS, 32'd0);
		write_reg(REG_ACK_TIMEOUT, 32'd1);
		test_random_traffic(325, 64, 0);
		write_reg(REG_DEVICE_ADDRESS, 32'd127);
		write_reg(REG_ACK_TIMEOUT, 32'd255);
		test_random_traffic(325, 0, 64);
		write_reg(REG_DEVICE_ADDRESS, $urandom_range(0, 127));
		write_reg(REG_ACK_TIMEOUT, $urandom_range(0, 7));
		test_random_traffic(325, 10, 10);

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("Checked %0d results from %0d effective items.", results_checked,
			useful_items);
		$display("%0d transfers ended (%0d on acknowledge timeout), %0d bytes read back.",
			transfers_done, transfers_failed, bytes_read);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/i2crm_pkg.sv
sv/i2c_register_master_top.sv
tb/i2c_register_master_top_tb.sv
